// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL of the gcd unit, included by its top level.
// Plain text macros, no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

// ----- rtl/gcdpf_pkg.sv -----
// Package for the gcd-by-prime-factors unit: sizes and controller states.
// No dependencies.
package gcdpf_pkg;
   localparam int VALUE_LIMIT = 4096;
   localparam int MAX_FACTORS = 12;
   localparam int OPER_W = 12;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_SIEVE_I,
      ST_SIEVE_RD,
      ST_SIEVE_MARK,
      ST_TRIAL,
      ST_TRIAL_RD,
      ST_DIV,
      ST_MERGE_RD,
      ST_MERGE,
      ST_MUL,
      ST_OUT
   } state_type;
endpackage

// ----- rtl/gcdpf_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module gcdpf_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data_ff <= mem[addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/gcdpf_divider.sv -----
// Restoring divider, one quotient bit per cycle, for trial division.
// Uses gcdpf_pkg for the operand width.
module gcdpf_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [gcdpf_pkg::OPER_W-1:0] dividend,
   input  logic [gcdpf_pkg::OPER_W-1:0] divisor,
   output logic                         done,
   output logic [gcdpf_pkg::OPER_W-1:0] quotient,
   output logic                         exact
);
   localparam int W = gcdpf_pkg::OPER_W;
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  quo_ff, quo_in;
   logic [W:0]    rem_ff, rem_in;
   logic [W-1:0]  dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    shifted;
   logic [W:0]    diff;

   // One shift-subtract step per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[W-1:0], quo_ff[W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[W]) begin
            rem_in = diff;
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign exact    = (rem_ff == '0);
endmodule

// ----- rtl/gcd_by_prime_factors_unit.sv -----
// Top level of the gcd-by-prime-factors unit: sequencer, sieve and list RAMs.
// Uses gcdpf_pkg, gcdpf_ram, gcdpf_divider and assert_macros.svh.
//
// Usage:
//   A request carries first_operand and second_operand on req_*; it is
//   accepted when req_valid is high and req_stall is low. The result,
//   divisor, appears on rsp_* and is held until rsp_stall is low.
//   One request is in work at a time; req_stall is high while busy.
//   Work: for each operand n (capped at VALUE_LIMIT-1) the sieve first
//   clears the marks up to n, then reads each index up to sqrt(n) and
//   marks the multiples of each unmarked one. Trial division then walks
//   the candidates up to the remaining value and runs the serial divider
//   on each prime candidate, and again on the quotient per factor found.
//   The merge takes up to 2*MAX_FACTORS read-compare steps, with an extra
//   multiply step when a factor is shared. The sieve RAM and the divider
//   set the run time; one RAM port serves every sieve access.
//   Reset returns the sequencer to idle; no RAM is cleared. A stalled
//   result keeps the unit busy until taken.
module gcd_by_prime_factors_unit #(
   parameter int VALUE_LIMIT = gcdpf_pkg::VALUE_LIMIT,
   parameter int MAX_FACTORS = gcdpf_pkg::MAX_FACTORS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [gcdpf_pkg::OPER_W-1:0] req_first_operand,
   input  logic [gcdpf_pkg::OPER_W-1:0] req_second_operand,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [gcdpf_pkg::OPER_W-1:0] rsp_divisor
);
`include "assert_macros.svh"
   localparam int W  = gcdpf_pkg::OPER_W;
   localparam int SW = $clog2(VALUE_LIMIT);
   localparam int FW = $clog2(MAX_FACTORS);
   localparam int CW = $clog2(MAX_FACTORS + 1);
   localparam int VW = (W > SW) ? W : SW;   // candidate width
   localparam logic [VW:0] TOP_MAX = (VW+1)'(VALUE_LIMIT - 1);

   gcdpf_pkg::state_type state_ff, state_in;

   logic [W-1:0]  opb_ff, opb_in;
   logic          which_ff, which_in;     // 0: first operand
   logic [VW:0]   top_ff, top_in;
   logic [W-1:0]  rest_ff, rest_in;
   logic [VW:0]   i_ff, i_in;             // sieve / candidate index
   logic [2*VW+1:0] j_ff, j_in;           // marking index
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] na_ff, na_in;
   logic [CW-1:0] ia_ff, ia_in, ib_ff, ib_in;
   logic [W-1:0]  fa_ff, fa_in;           // first list entry latched
   logic [19:0]   prod_ff, prod_in;
   logic [W-1:0]  res_ff, res_in;
   logic          rv_ff, rv_in;

   // sieve RAM port
   logic          s_we;
   logic [SW-1:0] s_addr;
   logic          s_wd, s_rd;
   // list RAM ports
   logic          la_we, lb_we;
   logic [FW-1:0] la_addr, lb_addr;
   logic [W-1:0]  l_wd, la_rd, lb_rd;
   // divider
   logic          d_start, d_done, d_exact;
   logic [W-1:0]  d_quo;

   gcdpf_ram #(.WIDTH(1), .DEPTH(VALUE_LIMIT)) u_sieve (
      .clock(clock), .wr_en(s_we), .addr(s_addr), .wr_data(s_wd), .rd_data(s_rd));
   gcdpf_ram #(.WIDTH(W), .DEPTH(MAX_FACTORS)) u_list_a (
      .clock(clock), .wr_en(la_we), .addr(la_addr), .wr_data(l_wd), .rd_data(la_rd));
   gcdpf_ram #(.WIDTH(W), .DEPTH(MAX_FACTORS)) u_list_b (
      .clock(clock), .wr_en(lb_we), .addr(lb_addr), .wr_data(l_wd), .rd_data(lb_rd));
   gcdpf_divider u_div (
      .clock(clock), .reset(reset), .start(d_start), .dividend(rest_ff),
      .divisor(i_ff[W-1:0]), .done(d_done), .quotient(d_quo), .exact(d_exact));

   logic [2*VW+3:0] isq;
   logic [31:0]     mulv;
   assign isq  = (2*VW+4)'(i_ff) * (2*VW+4)'(i_ff);
   assign mulv = 32'(prod_ff) * 32'(fa_ff);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      opb_in = opb_ff; which_in = which_ff;
      top_in = top_ff; rest_in = rest_ff; i_in = i_ff; j_in = j_ff;
      cnt_in = cnt_ff; na_in = na_ff; ia_in = ia_ff; ib_in = ib_ff;
      fa_in = fa_ff; prod_in = prod_ff; res_in = res_ff; rv_in = rv_ff;
      s_we = 1'b0; s_addr = i_ff[SW-1:0]; s_wd = 1'b0;
      la_we = 1'b0; lb_we = 1'b0; la_addr = ia_ff[FW-1:0]; lb_addr = ib_ff[FW-1:0];
      l_wd = i_ff[W-1:0];
      d_start = 1'b0;
      req_stall = 1'b1;
      unique case (state_ff)
         gcdpf_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               opb_in = req_second_operand;
               which_in = 1'b0;
               top_in = ((VW+1)'(req_first_operand) > TOP_MAX) ? TOP_MAX
                        : (VW+1)'(req_first_operand);
               rest_in = req_first_operand;
               i_in = '0;
               state_in = gcdpf_pkg::ST_INIT;
            end
         end
         // clear marks: entry i prime-candidate iff i >= 2
         gcdpf_pkg::ST_INIT: begin
            if (i_ff > top_ff) begin
               i_in = (VW+1)'(2);
               state_in = gcdpf_pkg::ST_SIEVE_I;
            end else begin
               s_we = 1'b1;
               s_wd = (i_ff >= (VW+1)'(2));
               i_in = i_ff + 1'b1;
            end
         end
         gcdpf_pkg::ST_SIEVE_I: begin
            if ((2*VW+4)'(top_ff) < isq) begin
               i_in = (VW+1)'(2);
               cnt_in = '0;
               state_in = gcdpf_pkg::ST_TRIAL;
            end else begin
               state_in = gcdpf_pkg::ST_SIEVE_RD;
            end
         end
         gcdpf_pkg::ST_SIEVE_RD: begin
            if (s_rd) begin
               j_in = isq[2*VW+1:0];
               state_in = gcdpf_pkg::ST_SIEVE_MARK;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = gcdpf_pkg::ST_SIEVE_I;
            end
         end
         gcdpf_pkg::ST_SIEVE_MARK: begin
            s_addr = j_ff[SW-1:0];
            if (j_ff > (2*VW+2)'(top_ff)) begin
               i_in = i_ff + 1'b1;
               state_in = gcdpf_pkg::ST_SIEVE_I;
            end else begin
               s_we = 1'b1;
               j_in = j_ff + (2*VW+2)'(i_ff);
            end
         end
         // trial candidate p = i
         gcdpf_pkg::ST_TRIAL: begin
            if (i_ff > (VW+1)'(rest_ff)) begin
               if (!which_ff) begin
                  na_in = cnt_ff;
                  which_in = 1'b1;
                  top_in = ((VW+1)'(opb_ff) > TOP_MAX) ? TOP_MAX : (VW+1)'(opb_ff);
                  rest_in = opb_ff;
                  i_in = '0;
                  state_in = gcdpf_pkg::ST_INIT;
               end else begin
                  ia_in = '0; ib_in = '0; prod_in = 20'd1;
                  state_in = gcdpf_pkg::ST_MERGE_RD;
               end
            end else begin
               state_in = gcdpf_pkg::ST_TRIAL_RD;
            end
         end
         gcdpf_pkg::ST_TRIAL_RD: begin
            if ((i_ff > top_ff) || s_rd) begin
               d_start = 1'b1;
               state_in = gcdpf_pkg::ST_DIV;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = gcdpf_pkg::ST_TRIAL;
            end
         end
         // exact: keep the factor (while the list has room) and retry the same candidate on the quotient
         gcdpf_pkg::ST_DIV: begin
            la_addr = cnt_ff[FW-1:0];
            lb_addr = cnt_ff[FW-1:0];
            if (d_done) begin
               if (d_exact) begin
                  rest_in = d_quo;
                  if (cnt_ff < CW'(MAX_FACTORS)) begin
                     la_we = !which_ff;
                     lb_we = which_ff;
                     cnt_in = cnt_ff + 1'b1;
                  end
                  state_in = gcdpf_pkg::ST_TRIAL;
               end else begin
                  i_in = i_ff + 1'b1;
                  state_in = gcdpf_pkg::ST_TRIAL;
               end
            end
         end
         gcdpf_pkg::ST_MERGE_RD: begin
            if ((ia_ff >= na_ff) || (ib_ff >= cnt_ff)) begin
               res_in = prod_ff[W-1:0];
               rv_in = 1'b1;
               state_in = gcdpf_pkg::ST_OUT;
            end else begin
               state_in = gcdpf_pkg::ST_MERGE;
            end
         end
         gcdpf_pkg::ST_MERGE: begin
            fa_in = la_rd;
            if (la_rd > lb_rd) begin
               ib_in = ib_ff + 1'b1;
               state_in = gcdpf_pkg::ST_MERGE_RD;
            end else if (la_rd < lb_rd) begin
               ia_in = ia_ff + 1'b1;
               state_in = gcdpf_pkg::ST_MERGE_RD;
            end else begin
               ia_in = ia_ff + 1'b1;
               ib_in = ib_ff + 1'b1;
               state_in = gcdpf_pkg::ST_MUL;
            end
         end
         gcdpf_pkg::ST_MUL: begin
            prod_in = mulv[19:0];
            state_in = gcdpf_pkg::ST_MERGE_RD;
         end
         gcdpf_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               rv_in = 1'b0;
               state_in = gcdpf_pkg::ST_IDLE;
            end
         end
         default: state_in = gcdpf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gcdpf_pkg::ST_IDLE;
         rv_ff    <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         cnt_ff   <= cnt_in;
      end
      opb_ff <= opb_in; which_ff <= which_in;
      top_ff <= top_in; rest_ff <= rest_in; i_ff <= i_in; j_ff <= j_in;
      na_ff <= na_in; ia_ff <= ia_in; ib_ff <= ib_in;
      fa_ff <= fa_in; prod_ff <= prod_in; res_ff <= res_in;
   end

   assign rsp_valid   = rv_ff;
   assign rsp_divisor = res_ff;

   `ASSERT_IMPLY(a_busy_stall, clock, reset, rv_ff, req_stall)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rv_ff && rsp_stall, rv_ff && $stable(res_ff))
   `ASSERT_IMPLY(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CW'(MAX_FACTORS))
endmodule

// ----- test/gcd_by_prime_factors_unit_test.sv -----
// Testbench for gcd_by_prime_factors_unit: random and directed operand pairs, checked
// against a factorization-based divisor predictor held in a small scoreboard class.
// Depends on gcdpf_pkg and the unit's RTL.
`timescale 1ns / 100ps

module gcd_by_prime_factors_unit_test;
   localparam int OPER_W = gcdpf_pkg::OPER_W;
   localparam int VALUE_LIMIT = gcdpf_pkg::VALUE_LIMIT;
   localparam int MAX_FACTORS = gcdpf_pkg::MAX_FACTORS;

   localparam int unsigned CYCLE_LIMIT = 40_000_000;
   localparam int unsigned DRAIN_CYCLES = 200;
   localparam int unsigned RANDOM_REQUESTS = 100;

   // Expected divisors, one per accepted request, oldest first
   class divisor_scoreboard;
      bit [OPER_W-1:0] pending_divisors[$];
      int unsigned mismatches;
      bit prime_marks[VALUE_LIMIT];

      // Sieve up to the operand, then trial division by the marked primes
      function void factor_operand(input bit [OPER_W-1:0] value,
                                   ref bit [OPER_W-1:0] factors[$]);
         int unsigned top;
         int unsigned rest;
         int unsigned p;
         int unsigned q;
         top = value;
         rest = value;
         factors.delete();
         for (p = 0; p <= top; p++) prime_marks[p] = (p >= 2);
         for (p = 2; p * p <= top; p++) begin
            if (prime_marks[p]) begin
               for (q = p * p; q <= top; q += p) prime_marks[q] = 0;
            end
         end
         for (p = 2; p <= rest; p++) begin
            if (prime_marks[p]) begin
               while (rest % p == 0) begin
                  rest = rest / p;
                  if (factors.size() < MAX_FACTORS) factors.push_back(p[OPER_W-1:0]);
               end
            end
         end
      endfunction

      function void note_request(input bit [OPER_W-1:0] first, input bit [OPER_W-1:0] second);
         bit [OPER_W-1:0] first_factors[$];
         bit [OPER_W-1:0] second_factors[$];
         int unsigned i;
         int unsigned j;
         int unsigned product;
         factor_operand(first, first_factors);
         factor_operand(second, second_factors);
         i = 0;
         j = 0;
         product = 1;
         // Walk both ascending lists, keep the shared primes
         while (i < first_factors.size() && j < second_factors.size()) begin
            if (first_factors[i] > second_factors[j]) j++;
            else if (first_factors[i] < second_factors[j]) i++;
            else begin
               product = (product * first_factors[i]) & 32'hFFFFF;
               i++;
               j++;
            end
         end
         pending_divisors.push_back(product[OPER_W-1:0]);
      endfunction

      function void check_divisor(input bit [OPER_W-1:0] actual);
         bit [OPER_W-1:0] expected;
         if (pending_divisors.size() == 0) begin
            $display("%0t: unexpected divisor %0d", $time, actual);
            mismatches++;
         end else begin
            expected = pending_divisors.pop_front();
            if (expected != actual) begin
               $display("%0t: divisor expected %0d actual %0d", $time, expected, actual);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [OPER_W-1:0] req_first_operand = '0;
   logic [OPER_W-1:0] req_second_operand = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [OPER_W-1:0] rsp_divisor;

   divisor_scoreboard board = new();
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct = 21;
   int unsigned take_idle_pct = 63;

   gcd_by_prime_factors_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_first_operand(req_first_operand),
      .req_second_operand(req_second_operand),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_divisor(rsp_divisor)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // Watch both channels at the rising edge; give up at the cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_valid && !req_stall) board.note_request(req_first_operand, req_second_operand);
         if (rsp_valid && !rsp_stall) board.check_divisor(rsp_divisor);
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Result side back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < take_idle_pct);
   end

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input logic [OPER_W-1:0] first, input logic [OPER_W-1:0] second);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_first_operand <= first;
      req_second_operand <= second;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Mostly small operands keep the sieve short; a few span all 12 bits
   function automatic logic [OPER_W-1:0] pick_operand(input int unsigned shared);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 12) return OPER_W'($urandom_range(4095));
      if (roll < 60) return OPER_W'(shared * $urandom_range(1, 255 / shared));
      return OPER_W'($urandom_range(255));
   endfunction

   task automatic wait_until_drained();
      while (board.pending_divisors.size() != 0) @(negedge clock);
   endtask

   initial begin
      int unsigned n;
      int unsigned shared;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: zeros, ones, extremes, primes, powers of two
      send_request(1, 1);
      send_request(0, 0);
      send_request(0, 5);
      send_request(7, 0);
      send_request(1, 4095);
      send_request(4095, 4095);
      send_request(2048, 1024);
      send_request(2048, 4095);
      send_request(4093, 4093);
      send_request(4094, 2047);
      send_request(12, 18);
      send_request(3960, 2520);
      send_request(97, 194);
      send_request(2310, 1155);
      send_request(64, 48);

      // Sender holds off until every result is back
      req_valid <= 0;
      @(negedge clock);
      wait_until_drained();

      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == RANDOM_REQUESTS / 3) begin
            send_idle_pct = 63;
            take_idle_pct = 21;
         end else if (n == 2 * RANDOM_REQUESTS / 3) begin
            send_idle_pct = 0;
            take_idle_pct = 0;
         end
         shared = $urandom_range(1, 15);
         send_request(pick_operand(shared), pick_operand(shared));
      end
      req_valid <= 0;

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending_divisors.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
